### sv/xkbc_pkg.sv
// Package for the xorshift keystream byte cipher.
// Seed reset values, shift amounts, shared types and the generator step function.
// No dependencies.
package xkbc_pkg;

  localparam int unsigned NumSeeds  = 4;
  localparam int unsigned WordW     = 32;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned AddrW     = 4;

  localparam int unsigned ShiftA    = 11;
  localparam int unsigned ShiftB    = 8;
  localparam int unsigned ShiftC    = 19;

  localparam logic [WordW-1:0] Seed0Rst = 32'h075B_CD15;
  localparam logic [WordW-1:0] Seed1Rst = 32'h159A_55E5;
  localparam logic [WordW-1:0] Seed2Rst = 32'h1F12_3BB5;
  localparam logic [WordW-1:0] Seed3Rst = 32'h174E_897D;

  typedef logic [NumSeeds-1:0][WordW-1:0] words_t;

  // Per-item request from the datapath to the keystream generator.
  typedef struct packed {
    logic fire;     // an item is processed this cycle
    logic restart;  // reload seed and drop the keystream word first
  } kg_req_t;

  // One xorshift128 step: returns the new word set, newest word in [3].
  function automatic words_t xs_step(input words_t w);
    logic [WordW-1:0] t;
    logic [WordW-1:0] n;
    words_t           r;
    t    = w[0] ^ (w[0] << ShiftA);
    n    = t ^ (t >> ShiftB) ^ w[3] ^ (w[3] >> ShiftC);
    r[0] = w[1];
    r[1] = w[2];
    r[2] = w[3];
    r[3] = n;
    return r;
  endfunction

endpackage

### sv/xkbc_cfg_regs.sv
// APB-style register file holding the four generator seed words.
// Depends on xkbc_pkg.
module xkbc_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [xkbc_pkg::AddrW-1:0]   paddr,
  input  logic [xkbc_pkg::WordW-1:0]   pwdata,
  output logic [xkbc_pkg::WordW-1:0]   prdata,
  output logic                         pready,
  output xkbc_pkg::words_t             seed_o
);

  xkbc_pkg::words_t seed_q;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];
  assign prdata  = seed_q[reg_idx];
  assign seed_o  = seed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q[0] <= xkbc_pkg::Seed0Rst;
      seed_q[1] <= xkbc_pkg::Seed1Rst;
      seed_q[2] <= xkbc_pkg::Seed2Rst;
      seed_q[3] <= xkbc_pkg::Seed3Rst;
    end else if (wr_en) begin
      seed_q[reg_idx] <= pwdata;
    end
  end

endmodule

### sv/xkbc_keygen.sv
// Keystream generator: xorshift128 state plus the partly used keystream word.
// Depends on xkbc_pkg.
module xkbc_keygen (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  xkbc_pkg::kg_req_t             req_i,
  input  xkbc_pkg::words_t              seed_i,
  output logic [xkbc_pkg::ByteW-1:0]    key_byte_o
);

  xkbc_pkg::words_t              gen_q, gen_d;
  logic [xkbc_pkg::WordW-1:0]    stream_q, stream_d;
  xkbc_pkg::words_t              gen_base;
  logic [xkbc_pkg::WordW-1:0]    stream_base;
  xkbc_pkg::words_t              gen_next;
  logic [xkbc_pkg::WordW-1:0]    stream_cur;

  // Restart first, then refill when the word is used up (zero).
  always_comb begin
    gen_base    = req_i.restart ? seed_i : gen_q;
    stream_base = req_i.restart ? '0 : stream_q;
    gen_next    = xkbc_pkg::xs_step(gen_base);
    if (stream_base == '0) begin
      gen_d      = gen_next;
      stream_cur = gen_next[3];
    end else begin
      gen_d      = gen_base;
      stream_cur = stream_base;
    end
    stream_d   = stream_cur >> xkbc_pkg::ByteW;
    key_byte_o = stream_cur[xkbc_pkg::ByteW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gen_q[0] <= xkbc_pkg::Seed0Rst;
      gen_q[1] <= xkbc_pkg::Seed1Rst;
      gen_q[2] <= xkbc_pkg::Seed2Rst;
      gen_q[3] <= xkbc_pkg::Seed3Rst;
      stream_q <= '0;
    end else if (req_i.fire) begin
      gen_q    <= gen_d;
      stream_q <= stream_d;
    end
  end

  // Restart always forces a step, so the seed shows up shifted by one word.
  a_restart_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.fire && req_i.restart |=>
      gen_q[0] == $past(seed_i[1]) && gen_q[2] == $past(seed_i[3]))
    else $error("restart did not reload and step the generator");

  a_idle_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.fire |=> $stable(gen_q) && $stable(stream_q))
    else $error("generator state moved without an item");

  a_no_early_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.fire && !req_i.restart && stream_q != '0 |=>
      gen_q == $past(gen_q))
    else $error("generator stepped while keystream bytes remained");

endmodule

### sv/xorshift_keystream_byte_cipher_top.sv
// Top level of the xorshift keystream byte cipher.
// Depends on xkbc_pkg, xkbc_cfg_regs and xkbc_keygen.
//
// Usage:
//   Input stream (s_axis_*): one byte per item in tdata; tuser carries the
//   restart flag, which reloads the generator from the seed registers and
//   drops the current keystream word before this byte is transformed.
//   Output stream (m_axis_*): one transformed byte per input item, in order.
//   The same block encrypts and decrypts.
//   Config port (APB): four 32-bit seed words at byte addresses 0, 4, 8, 12.
//   A seed write only takes effect at the next restart; write while idle.
// Timing:
//   An accepted item sits in the input register, is combined with the
//   keystream as it moves to the output register and then shows on m_axis.
//   Throughput is one item per cycle unless m_axis_tready stalls; the limit
//   is the combinational generator step plus XOR between the registers.
// Reset: seed registers take their default values, the generator is loaded
//   from them and the keystream word is cleared; both streams come up empty.
// Stall: when m_axis_tready is low the output register holds, the input
//   register fills, and s_axis_tready drops until the output drains.
module xorshift_keystream_byte_cipher_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input item stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] data_byte
  input  logic                        s_axis_tuser,   // [0] restart
  // result item stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [xkbc_pkg::AddrW-1:0]  paddr,
  input  logic [xkbc_pkg::WordW-1:0]  pwdata,
  output logic [xkbc_pkg::WordW-1:0]  prdata,
  output logic                        pready
);

  xkbc_pkg::words_t             seed;
  xkbc_pkg::kg_req_t            kg_req;
  logic [xkbc_pkg::ByteW-1:0]   key_byte;

  // Input register stage
  logic                         in_valid_q, in_valid_d;
  logic [xkbc_pkg::ByteW-1:0]   in_byte_q;
  logic                         in_restart_q;
  // Output register stage
  logic                         out_valid_q, out_valid_d;
  logic [xkbc_pkg::ByteW-1:0]   out_byte_q;

  logic s_fire;
  logic advance;  // input stage item moves into the output register

  xkbc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .seed_o  (seed)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  assign kg_req.fire    = advance;
  assign kg_req.restart = in_restart_q;

  xkbc_keygen u_keygen (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (kg_req),
    .seed_i     (seed),
    .key_byte_o (key_byte)
  );

  always_comb begin
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end else begin
      in_valid_d = in_valid_q;
    end
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers, no reset needed.
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q    <= s_axis_tdata;
      in_restart_q <= s_axis_tuser;
    end
    if (advance) begin
      out_byte_q <= in_byte_q ^ key_byte;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item did not reach the output register");

  a_blocked_input_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_byte_q))
    else $error("stalled input stage lost its item");

  a_full_stall_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted with both stages full and stalled");

endmodule

### verif/tb_top.sv
// Self-checking testbench for xorshift_keystream_byte_cipher_top.
// Drives byte items and APB seed writes, predicts every output byte and checks it.
// Depends on xkbc_pkg and the cipher RTL.
`timescale 1ns / 1ps

module tb_top;

  // Seed registers as seen on the APB port, one word per 4-byte slot.
  typedef enum int unsigned {
    REG_SEED0,
    REG_SEED1,
    REG_SEED2,
    REG_SEED3
  } seed_reg_e;

  // One row of the directed table. When wr_seeds is set the seeds are loaded
  // (block idle) before the item goes out. When fixed is set, want is the
  // expected byte; otherwise the predictor supplies it.
  typedef struct packed {
    logic             wr_seeds;
    xkbc_pkg::words_t seeds;      // {word3, word2, word1, word0}
    logic [7:0]       data;
    logic             restart;
    logic             fixed;
    logic [7:0]       want;
  } dir_row_t;

  localparam int unsigned StallLimit = 1000;  // cycles without any handshake
  localparam int unsigned RandPerPhase = 184;
  localparam int unsigned DirRows = 22;

  localparam xkbc_pkg::words_t NoSeeds   = '0;
  localparam xkbc_pkg::words_t SeedsZero = '0;
  localparam xkbc_pkg::words_t SeedsOnes = '1;
  // Only word3 = 1: the generator emits 1, 1, 1, 0x808, 1 ... so the
  // keystream word runs dry after one byte and the upper-byte refill kicks in.
  localparam xkbc_pkg::words_t SeedsLow  = {32'd1, 32'd0, 32'd0, 32'd0};
  localparam xkbc_pkg::words_t SeedsDflt = {xkbc_pkg::Seed3Rst, xkbc_pkg::Seed2Rst,
                                            xkbc_pkg::Seed1Rst, xkbc_pkg::Seed0Rst};

  // Directed items. Typed expectations only where the keystream is obvious:
  // zero generator (byte passes through) and the low seed set above.
  dir_row_t dir_tab [DirRows] = '{
    // reset seeds, generator fresh out of reset
    '{1'b0, NoSeeds,   8'h00, 1'b0, 1'b0, 8'h00},
    '{1'b0, NoSeeds,   8'hFF, 1'b0, 1'b0, 8'h00},
    '{1'b0, NoSeeds,   8'hA5, 1'b0, 1'b0, 8'h00},
    '{1'b0, NoSeeds,   8'h5A, 1'b0, 1'b0, 8'h00},
    '{1'b0, NoSeeds,   8'h3C, 1'b1, 1'b0, 8'h00},
    '{1'b0, NoSeeds,   8'hC3, 1'b0, 1'b0, 8'h00},
    // new seeds, but no restart yet: old generator keeps running
    '{1'b1, SeedsLow,  8'h11, 1'b0, 1'b0, 8'h00},
    '{1'b0, NoSeeds,   8'h00, 1'b1, 1'b1, 8'h01},
    '{1'b0, NoSeeds,   8'hFF, 1'b0, 1'b1, 8'hFE},
    '{1'b0, NoSeeds,   8'h80, 1'b0, 1'b1, 8'h81},
    '{1'b0, NoSeeds,   8'h7F, 1'b0, 1'b1, 8'h77},
    '{1'b0, NoSeeds,   8'h00, 1'b0, 1'b1, 8'h08},
    '{1'b0, NoSeeds,   8'hF0, 1'b0, 1'b1, 8'hF1},
    // all-zero seed: generator stuck at zero, bytes pass unchanged
    '{1'b1, SeedsZero, 8'h5A, 1'b1, 1'b1, 8'h5A},
    '{1'b0, NoSeeds,   8'hFF, 1'b0, 1'b1, 8'hFF},
    '{1'b0, NoSeeds,   8'h00, 1'b0, 1'b1, 8'h00},
    // all-ones seed written; zero generator runs until the restart
    '{1'b1, SeedsOnes, 8'h00, 1'b0, 1'b1, 8'h00},
    '{1'b0, NoSeeds,   8'h00, 1'b1, 1'b0, 8'h00},
    '{1'b0, NoSeeds,   8'hFF, 1'b0, 1'b0, 8'h00},
    '{1'b0, NoSeeds,   8'h81, 1'b0, 1'b0, 8'h00},
    '{1'b0, NoSeeds,   8'h7E, 1'b1, 1'b0, 8'h00},
    // back to the reset values
    '{1'b1, SeedsDflt, 8'h00, 1'b1, 1'b0, 8'h00}
  };

  // DUT signals, all known from time zero.
  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata  = '0;   // [7:0] data_byte
  logic                           s_axis_tuser  = 1'b0; // [0] restart
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [7:0]                     m_axis_tdata;         // [7:0] out_byte
  logic                           psel          = 1'b0;
  logic                           penable       = 1'b0;
  logic                           pwrite        = 1'b0;
  logic [xkbc_pkg::AddrW-1:0]     paddr         = '0;
  logic [xkbc_pkg::WordW-1:0]     pwdata        = '0;
  logic [xkbc_pkg::WordW-1:0]     prdata;
  logic                           pready;

  // Predictor state: seed registers, generator words, current keystream word.
  xkbc_pkg::words_t               ks_seed = SeedsDflt;
  xkbc_pkg::words_t               ks_gen  = SeedsDflt;
  logic [xkbc_pkg::WordW-1:0]     ks_word = '0;

  logic [7:0]       pending_out_q [$];  // expected output bytes, oldest first
  int unsigned      err_cnt      = 0;
  int unsigned      quiet_cycles = 0;
  int unsigned      src_idle_pct = 0;
  int unsigned      snk_idle_pct = 0;

  xorshift_keystream_byte_cipher_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Encrypt one byte: optional reload from seeds, refill when the keystream
  // word is empty (zero upper bytes count as empty), XOR, shift out a byte.
  function automatic logic [7:0] keystream_xor(input logic [7:0] din, input logic restart);
    logic [xkbc_pkg::WordW-1:0] t;
    logic [xkbc_pkg::WordW-1:0] n;
    if (restart) begin
      ks_gen  = ks_seed;
      ks_word = '0;
    end
    if (ks_word == '0) begin
      t       = ks_gen[0] ^ (ks_gen[0] << xkbc_pkg::ShiftA);
      n       = t ^ (t >> xkbc_pkg::ShiftB) ^ ks_gen[3] ^ (ks_gen[3] >> xkbc_pkg::ShiftC);
      ks_gen  = {n, ks_gen[3], ks_gen[2], ks_gen[1]};
      ks_word = n;
    end
    keystream_xor = din ^ ks_word[7:0];
    ks_word       = ks_word >> 8;
  endfunction

  task automatic report_mismatch(input string what, input logic [xkbc_pkg::WordW-1:0] got,
                                 input logic [xkbc_pkg::WordW-1:0] want);
    $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
    err_cnt++;
  endtask

  // All stimulus tasks start and end at a falling edge.
  task automatic push_byte(input logic [7:0] din, input logic restart,
                           input logic fixed, input logic [7:0] want);
    logic [7:0] pred;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= din;
    s_axis_tuser  <= restart;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = keystream_xor(din, restart);
    pending_out_q.push_back(fixed ? want : pred);
    @(negedge clk_i);
  endtask

  // Stop sending and let every outstanding byte drain.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_out_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic apb_write(input seed_reg_e idx, input logic [xkbc_pkg::WordW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= xkbc_pkg::AddrW'(4 * idx);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    ks_seed[idx] = val;
    @(negedge clk_i);
  endtask

  // Read every seed back, then release the bus.
  task automatic verify_seeds();
    logic [xkbc_pkg::WordW-1:0] rd;
    for (int i = 0; i < xkbc_pkg::NumSeeds; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= xkbc_pkg::AddrW'(4 * i);
      @(negedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
      rd = prdata;
      if (rd !== ks_seed[i]) report_mismatch($sformatf("seed_word_%0d readback", i), rd,
                                             ks_seed[i]);
      @(negedge clk_i);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_seeds(input xkbc_pkg::words_t seeds);
    for (int i = 0; i < xkbc_pkg::NumSeeds; i++) apb_write(seed_reg_e'(i), seeds[i]);
    verify_seeds();
  endtask

  // Receiver: random back-pressure, changed on the falling edge.
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // Output checker: every accepted byte against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_out_q.size() == 0) begin
        report_mismatch("unexpected out_byte", xkbc_pkg::WordW'(m_axis_tdata), '0);
      end else begin
        if (m_axis_tdata !== pending_out_q[0]) begin
          report_mismatch("out_byte", xkbc_pkg::WordW'(m_axis_tdata),
                          xkbc_pkg::WordW'(pending_out_q[0]));
        end
        void'(pending_out_q.pop_front());
      end
    end
  end

  // Watchdog: any handshake on either stream or the APB port counts as progress.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    xkbc_pkg::words_t seeds;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // sender idles 17%, receiver 63% for the directed part and first random phase
    src_idle_pct = 17;
    snk_idle_pct = 63;
    verify_seeds();  // reset values

    for (int r = 0; r < DirRows; r++) begin
      if (dir_tab[r].wr_seeds) begin
        wait_idle();
        load_seeds(dir_tab[r].seeds);
      end
      push_byte(dir_tab[r].data, dir_tab[r].restart, dir_tab[r].fixed, dir_tab[r].want);
    end

    // Random phases: new seeds each phase, sparse words in the middle one so
    // the generator often leaves zero upper bytes and refills early.
    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          src_idle_pct = 17;
          snk_idle_pct = 63;
          for (int i = 0; i < xkbc_pkg::NumSeeds; i++) seeds[i] = $urandom;
        end
        1: begin
          src_idle_pct = 63;
          snk_idle_pct = 17;
          for (int i = 0; i < xkbc_pkg::NumSeeds; i++) seeds[i] = $urandom_range(0, 255);
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
          for (int i = 0; i < xkbc_pkg::NumSeeds; i++) begin
            case ($urandom_range(0, 2))
              0:       seeds[i] = '0;
              1:       seeds[i] = '1;
              default: seeds[i] = $urandom;
            endcase
          end
        end
      endcase
      load_seeds(seeds);
      for (int n = 0; n < RandPerPhase; n++) begin
        push_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 11) == 0), 1'b0, 8'h00);
      end
    end

    wait_idle();
    repeat (4) @(posedge clk_i);  // margin for stray outputs after the drain
    if (err_cnt == 0 && pending_out_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
